### sv/assert_macros.svh
// assertion helpers used by the checker file rsp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define RSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rsp_pkg.sv
`timescale 1ns / 1ps
package rsp_pkg;
    localparam int IN_W   = 16;   // coordinate width
    localparam int CD_W   = 15;   // centre distance width
    localparam int SQ_W   = 32;   // squared length width
    localparam int LEN_W  = 16;   // segment length width
    localparam int PROD_W = CD_W + IN_W;
    localparam int CC_W   = 2 * CD_W;
    localparam int OUT_W  = 14;
    localparam int RES_W  = 24;   // signed chord arithmetic width
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
    localparam logic [CD_W-1:0]  CD_RESET = CD_W'(4096);
endpackage

### sv/rsp_isqrt.sv
`timescale 1ns / 1ps
module rsp_isqrt #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_val,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [W/2-1:0] o_root,
    output logic [SW-1:0]  o_side
);
    localparam int N  = W / 2;
    localparam int RW = N + 2;

    logic          r_v [N];
    logic [W-1:0]  r_x [N];
    logic [RW-1:0] r_r [N];
    logic [N-1:0]  r_y [N];
    logic [SW-1:0] r_s [N];

    // one root bit per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic          v_in;
        logic [W-1:0]  x_in;
        logic [RW-1:0] r_in;
        logic [N-1:0]  y_in;
        logic [SW-1:0] s_in;
        logic [RW-1:0] n_r2;
        logic [RW-1:0] n_trial;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = i_val;
            assign r_in = '0;
            assign y_in = '0;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign x_in = r_x[k-1];
            assign r_in = r_r[k-1];
            assign y_in = r_y[k-1];
            assign s_in = r_s[k-1];
        end

        always_comb begin
            n_r2    = {r_in[RW-3:0], x_in[W-1:W-2]};
            n_trial = {y_in, 2'b01};
            n_ge    = (n_r2 >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_x[k] <= {x_in[W-3:0], 2'b00};
                r_r[k] <= n_ge ? (n_r2 - n_trial) : n_r2;
                r_y[k] <= {y_in[N-2:0], n_ge};
                r_s[k] <= s_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_y[N-1];
    assign o_side  = r_s[N-1];
endmodule

### sv/rsp_div.sv
`timescale 1ns / 1ps
module rsp_div #(
    parameter int NW = 31,
    parameter int DW = 16,
    parameter int QW = 15,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);
    // quotient is known to fit QW bits, so the top bits start as remainder
    localparam int RW = DW + 1;

    logic          r_v [QW];
    logic [QW-1:0] r_n [QW];
    logic [RW-1:0] r_r [QW];
    logic [QW-1:0] r_q [QW];
    logic [DW-1:0] r_d [QW];
    logic [SW-1:0] r_s [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [QW-1:0] n_in;
        logic [RW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [RW-1:0] n_r2;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign n_in = i_num[QW-1:0];
            assign r_in = RW'(i_num[NW-1:QW]);
            assign q_in = '0;
            assign d_in = i_den;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign n_in = r_n[k-1];
            assign r_in = r_r[k-1];
            assign q_in = r_q[k-1];
            assign d_in = r_d[k-1];
            assign s_in = r_s[k-1];
        end

        always_comb begin
            n_r2 = {r_in[DW-1:0], n_in[QW-1]};
            n_ge = (n_r2 >= {1'b0, d_in});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_n[k] <= {n_in[QW-2:0], 1'b0};
                r_r[k] <= n_ge ? (n_r2 - {1'b0, d_in}) : n_r2;
                r_q[k] <= {q_in[QW-2:0], n_ge};
                r_d[k] <= d_in;
                r_s[k] <= s_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_den   = r_d[QW-1];
    assign o_side  = r_s[QW-1];
endmodule

### sv/ray_sphere_path_length_unit.sv
`timescale 1ns / 1ps
// ray path length inside a unit sphere, fully pipelined
// input stream: one end point per transfer, tdata = {lateral_coord, axial_coord},
//   both signed fixed point with FRAC_BITS fraction bits; the ray runs from
//   the origin to that point
// output stream: one inside_length per input, unsigned, same format
// config: i_cfg_we writes centre_distance (sphere centre on the axis);
//   write only while the pipeline is empty
// pipeline: registered stages a and b, the segment length square root (one root
//   bit per stage), stage c, the divider (one quotient bit per stage), stages d
//   and e, the half chord square root (one root bit per stage), output register
// throughput: one transfer per cycle on both sides while the output is not stalled
// stall: when the output holds a transfer that is not taken, every stage
//   holds and o_s_axis_tready drops; nothing is dropped or repeated
// reset: pipeline valid bits clear, centre_distance returns to 4096 (1.0 at FRAC_BITS = 12)
module ray_sphere_path_length_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] axial_coord, [31:16] lateral_coord
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [13:0] inside_length, [15:14] zero
    input  logic        i_cfg_we,
    input  logic [rsp_pkg::CD_W-1:0] i_cfg_wdata
);
    import rsp_pkg::*;

    // half chord root argument: up to 2^(2F), rounded up to an even width
    localparam int ARG_W = 2 * FRAC_BITS + 2;
    localparam int H_W   = ARG_W / 2;
    localparam int CMP_W = (ARG_W > CC_W) ? ARG_W : CC_W;
    localparam logic [CMP_W-1:0] ONE2 = CMP_W'(1) << (2 * FRAC_BITS);
    localparam int S2_W  = 2 + CD_W + LEN_W;

    logic [CD_W-1:0] r_cd;
    logic            w_en;

    // whole pipeline advances unless the output transfer is stalled
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd <= CD_RESET;
        end else if (i_cfg_we) begin
            r_cd <= i_cfg_wdata;
        end
    end

    // stage a: magnitudes squared
    logic [IN_W-1:0] w_ax, w_lat, w_abs_a, w_abs_p;
    logic            r_a_v, r_a_sign;
    logic [IN_W-1:0] r_a_abs;
    logic [SQ_W-1:0] r_a_aa, r_a_pp;

    assign w_ax    = i_s_axis_tdata[IN_W-1:0];
    assign w_lat   = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign w_abs_a = w_ax[IN_W-1]  ? IN_W'((IN_W+1)'(0) - {1'b1, w_ax})  : w_ax;
    assign w_abs_p = w_lat[IN_W-1] ? IN_W'((IN_W+1)'(0) - {1'b1, w_lat}) : w_lat;

    // stage b: squared segment length
    logic            r_b_v, r_b_sign;
    logic [IN_W-1:0] r_b_abs;
    logic [SQ_W-1:0] r_b_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_s_axis_tvalid;
            r_b_v <= r_a_v;
        end
        if (w_en) begin
            r_a_sign <= w_ax[IN_W-1];
            r_a_abs  <= w_abs_a;
            r_a_aa   <= SQ_W'(w_abs_a) * SQ_W'(w_abs_a);
            r_a_pp   <= SQ_W'(w_abs_p) * SQ_W'(w_abs_p);
            r_b_sign <= r_a_sign;
            r_b_abs  <= r_a_abs;
            r_b_s    <= r_a_aa + r_a_pp;
        end
    end

    // segment length
    logic              w_l_v;
    logic [LEN_W-1:0]  w_l_len;
    logic [IN_W:0]     w_l_side;

    rsp_isqrt #(.W(SQ_W), .SW(IN_W + 1)) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_v),
        .i_val   (r_b_s),
        .i_side  ({r_b_sign, r_b_abs}),
        .o_valid (w_l_v),
        .o_root  (w_l_len),
        .o_side  (w_l_side)
    );

    // stage c: centre times axial magnitude
    logic              r_c_v, r_c_sign;
    logic [PROD_W-1:0] r_c_num;
    logic [LEN_W-1:0]  r_c_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_l_v;
        end
        if (w_en) begin
            r_c_sign <= w_l_side[IN_W];
            r_c_num  <= PROD_W'(r_cd) * PROD_W'(w_l_side[IN_W-1:0]);
            r_c_len  <= w_l_len;
        end
    end

    // projection of the centre onto the ray
    logic             w_q_v;
    logic [CD_W-1:0]  w_q;
    logic [LEN_W-1:0] w_q_len;
    logic             w_q_sign;

    rsp_div #(.NW(PROD_W), .DW(LEN_W), .QW(CD_W), .SW(1)) u_proj_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_num   (r_c_num),
        .i_den   (r_c_len),
        .i_side  (r_c_sign),
        .o_valid (w_q_v),
        .o_quot  (w_q),
        .o_den   (w_q_len),
        .o_side  (w_q_sign)
    );

    // stage d: squares of centre and projection
    logic             w_qc;
    logic [CD_W-1:0]  w_q_clip;
    logic             r_d_v, r_d_sign;
    logic [CD_W-1:0]  r_d_q;
    logic [LEN_W-1:0] r_d_len;
    logic [CC_W-1:0]  r_d_cc, r_d_qq;

    assign w_qc     = (w_q > r_cd);
    assign w_q_clip = w_qc ? r_cd : w_q;

    // stage e: squared miss distance and half chord argument
    logic [CMP_W-1:0] w_m;
    logic             r_e_v, r_e_sign, r_e_miss;
    logic [CD_W-1:0]  r_e_q;
    logic [LEN_W-1:0] r_e_len;
    logic [ARG_W-1:0] r_e_arg;

    assign w_m = CMP_W'(r_d_cc - r_d_qq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= w_q_v;
            r_e_v <= r_d_v;
        end
        if (w_en) begin
            r_d_sign <= w_q_sign;
            r_d_q    <= w_q_clip;
            r_d_len  <= w_q_len;
            r_d_cc   <= CC_W'(r_cd) * CC_W'(r_cd);
            r_d_qq   <= CC_W'(w_q_clip) * CC_W'(w_q_clip);
            r_e_sign <= r_d_sign;
            r_e_q    <= r_d_q;
            r_e_len  <= r_d_len;
            r_e_miss <= (w_m >= ONE2);
            r_e_arg  <= ARG_W'(ONE2 - w_m);
        end
    end

    // half chord
    logic            w_h_v;
    logic [H_W-1:0]  w_h;
    logic [S2_W-1:0] w_h_side;

    rsp_isqrt #(.W(ARG_W), .SW(S2_W)) u_chord_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e_v),
        .i_val   (r_e_arg),
        .i_side  ({r_e_miss, r_e_sign, r_e_q, r_e_len}),
        .o_valid (w_h_v),
        .o_root  (w_h),
        .o_side  (w_h_side)
    );

    // stage f: clip chord to the segment
    logic                    w_f_miss, w_f_sign;
    logic [CD_W-1:0]         w_f_q;
    logic [LEN_W-1:0]        w_f_len;
    logic signed [RES_W-1:0] w_t, w_hs, w_ls, w_entry, w_exit, w_hi, w_lo, w_diff;
    logic [OUT_W-1:0]        w_res;
    logic                    r_o_v;
    logic [OUT_W-1:0]        r_o_res;

    always_comb begin
        w_f_len  = w_h_side[LEN_W-1:0];
        w_f_q    = w_h_side[LEN_W+CD_W-1:LEN_W];
        w_f_sign = w_h_side[S2_W-2];
        w_f_miss = w_h_side[S2_W-1];
        w_t      = w_f_sign ? -$signed(RES_W'(w_f_q)) : $signed(RES_W'(w_f_q));
        w_hs     = $signed(RES_W'(w_h));
        w_ls     = $signed(RES_W'(w_f_len));
        w_entry  = w_t - w_hs;
        w_exit   = w_t + w_hs;
        w_hi     = (w_ls < w_exit) ? w_ls : w_exit;
        w_lo     = (w_entry > 0) ? w_entry : '0;
        w_diff   = w_hi - w_lo;
        if (w_f_miss || (w_f_len == '0) || (w_diff < 0)) begin
            w_res = '0;
        end else if (w_diff > $signed(RES_W'(OUT_MAX))) begin
            w_res = OUT_MAX;
        end else begin
            w_res = OUT_W'(w_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= w_h_v;
        end
        if (w_en) begin
            r_o_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {2'b00, r_o_res};
endmodule

### sv/rsp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);
    `RSP_ASSERT_ALWAYS(a_rst_empty, i_clk, (!i_rst_n |=> !o_m_axis_tvalid), "valid after reset")
    `RSP_ASSERT(a_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled output changed")
    `RSP_ASSERT(a_pad, i_clk, i_rst_n, (o_m_axis_tvalid |-> o_m_axis_tdata[15:14] == 2'b00), "pad bits set")
    `RSP_ASSERT(a_empty_ready, i_clk, i_rst_n, (!o_m_axis_tvalid |-> o_s_axis_tready), "not ready while empty")
    `RSP_ASSERT(a_flow_ready, i_clk, i_rst_n, (i_m_axis_tready |-> o_s_axis_tready), "not ready while sink takes")
endmodule

bind ray_sphere_path_length_unit rsp_checker u_rsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
